// ----- rtl/scs_pkg.sv -----
// Shared types and constants of the sequencer step clock.
// Used by scs_core and sequencer_step_clock_with_swing; no dependencies.
package scs_pkg;

    // Item function codes.
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_START   = 2'd1;
    localparam logic [1:0] FUNC_STOP    = 2'd2;
    localparam logic [1:0] FUNC_SET_LEN = 2'd3;

    // Clock source codes held in the clock mode register.
    localparam logic [1:0] MODE_INTERNAL = 2'd0;
    localparam logic [1:0] MODE_MIDI     = 2'd1;
    localparam logic [1:0] MODE_TRIGGER  = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWING      = 1'b1;
    localparam int unsigned CFG_DATA_W     = 8;

    // Step length limits and reset value, in microseconds.
    localparam logic [31:0] STEP_LEN_MIN   = 32'd32000;
    localparam logic [31:0] STEP_LEN_MAX   = 32'd1024000;
    localparam logic [31:0] STEP_LEN_RESET = 32'd125000;

    typedef struct packed {
        logic [1:0]  func;
        logic        midi_pulse;
        logic        trigger_pulse;
        logic [31:0] new_step_length;
    } t_scs_item;

    typedef struct packed {
        logic [1:0] clock_mode;
        logic [7:0] swing_fraction;
    } t_scs_cfg;

    typedef struct packed {
        logic        step_now;
        logic [15:0] step_index;
        logic [31:0] step_length;
    } t_scs_result;

endpackage

// ----- rtl/scs_swing_mul.sv -----
// Swing amount: step length times an 8-bit fraction of 1/256, truncated.
// Depends on nothing but its ports.
module scs_swing_mul (
    input  logic [31:0] i_len,
    input  logic [7:0]  i_frac,
    output logic [31:0] o_amount
);

    logic [39:0] product;

    // The exact 40-bit product; dropping eight fraction bits gives the floor.
    assign product  = 40'(i_len) * 40'(i_frac);
    assign o_amount = product[39:8];

endmodule

// ----- rtl/scs_core.sv -----
// Step clock state and the single-pass update for one beat.
// Depends on scs_pkg and scs_swing_mul.
module scs_core #(
    parameter int unsigned PULSES_PER_STEP = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  scs_pkg::t_scs_item  i_item,
    input  scs_pkg::t_scs_cfg   i_cfg,
    output scs_pkg::t_scs_result o_res
);
    import scs_pkg::*;

    localparam logic [2:0] PULSE_RELOAD = 3'(PULSES_PER_STEP - 1);

    logic [31:0] r_time, n_time;
    logic [31:0] r_len, n_len;
    logic [31:0] r_last, n_last;
    logic [31:0] r_next, n_next;
    logic [31:0] r_swing, n_swing;
    logic [2:0]  r_pc, n_pc;
    logic [15:0] r_cnt, n_cnt;
    logic        r_pend, n_pend;

    logic [31:0] time_inc;
    logic [31:0] mul_op;
    logic [31:0] swing_amt;
    logic        midi_mode;
    logic        midi_reload;
    logic [31:0] midi_swing;
    logic [31:0] due;
    logic        reached;
    logic        stepped;

    // In MIDI mode the multiplier sees the freshly measured step length.
    assign time_inc  = r_time + 32'd1;
    assign midi_mode = (i_cfg.clock_mode == MODE_MIDI);
    assign mul_op    = midi_mode ? (time_inc - r_next) : r_len;

    scs_swing_mul u_mul (
        .i_len    (mul_op),
        .i_frac   (i_cfg.swing_fraction),
        .o_amount (swing_amt)
    );

    assign midi_reload = midi_mode && i_item.midi_pulse && (r_pc >= PULSE_RELOAD);
    assign midi_swing  = r_cnt[0] ? swing_amt : 32'd0;

    // One deadline adder serves both timed modes; a MIDI step that is
    // measured in this beat is judged against its new deadline.
    assign due     = midi_reload ? (time_inc + midi_swing) : (r_next + r_swing);
    assign reached = (time_inc >= due);

    always_comb begin
        n_time  = r_time;
        n_len   = r_len;
        n_last  = r_last;
        n_next  = r_next;
        n_swing = r_swing;
        n_pc    = r_pc;
        n_cnt   = r_cnt;
        n_pend  = r_pend;
        stepped = 1'b0;
        case (i_item.func)
            FUNC_TICK: begin
                n_time = time_inc;
                case (i_cfg.clock_mode)
                    MODE_INTERNAL: begin
                        if (reached) begin
                            n_last  = r_next;
                            n_next  = r_next + r_len;
                            n_swing = r_cnt[0] ? 32'd0 : swing_amt;
                            stepped = 1'b1;
                        end
                    end
                    MODE_MIDI: begin
                        if (midi_reload) begin
                            n_pc    = 3'd0;
                            n_len   = mul_op;
                            n_next  = time_inc;
                            n_swing = midi_swing;
                            n_pend  = 1'b1;
                        end else if (i_item.midi_pulse) begin
                            n_pc = 3'(r_pc + 3'd1);
                        end
                        if ((midi_reload || r_pend) && reached) begin
                            n_pend  = 1'b0;
                            stepped = 1'b1;
                        end
                    end
                    MODE_TRIGGER: begin
                        stepped = i_item.trigger_pulse;
                    end
                    default: begin
                    end
                endcase
                if (stepped) begin
                    n_cnt = r_cnt + 16'd1;
                end
            end
            FUNC_START: begin
                n_pc    = PULSE_RELOAD;
                n_cnt   = 16'd0;
                n_swing = 32'd0;
                n_pend  = 1'b0;
                n_next  = r_time;
            end
            FUNC_STOP: begin
                n_pc  = PULSE_RELOAD;
                n_cnt = 16'd0;
            end
            default: begin
                if (i_item.new_step_length < STEP_LEN_MIN) begin
                    n_len = STEP_LEN_MIN;
                end else if (i_item.new_step_length > STEP_LEN_MAX) begin
                    n_len = STEP_LEN_MAX;
                end else begin
                    n_len = i_item.new_step_length;
                end
                n_next = r_last + n_len;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= 32'd0;
            r_len   <= STEP_LEN_RESET;
            r_last  <= 32'd0;
            r_next  <= 32'd0;
            r_swing <= 32'd0;
            r_pc    <= PULSE_RELOAD;
            r_cnt   <= 16'd0;
            r_pend  <= 1'b0;
        end else if (i_fire) begin
            r_time  <= n_time;
            r_len   <= n_len;
            r_last  <= n_last;
            r_next  <= n_next;
            r_swing <= n_swing;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    assign o_res.step_now    = stepped;
    assign o_res.step_index  = n_cnt;
    assign o_res.step_length = n_len;

    a_len_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.func == FUNC_SET_LEN)
        |=> (r_len >= STEP_LEN_MIN && r_len <= STEP_LEN_MAX))
        else $error("step length left the clamp range after a length write");

    a_pc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PULSE_RELOAD)
        else $error("pulse count beyond reload value");

    a_time_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_fire && i_item.func == FUNC_TICK) |=> $stable(r_time))
        else $error("time counter moved without a tick beat");

endmodule

// ----- rtl/sequencer_step_clock_with_swing.sv -----
// Top level of the sequencer step clock: beat registers, configuration registers.
// Depends on scs_pkg and scs_core.

// Sequencer step clock with swing. Every input beat is a microsecond tick,
// a start, a stop or a step length write, and every beat yields exactly one
// result beat carrying step_now, the 16-bit step index and the step length
// in use. The block takes one beat per clock cycle while o_stall is low;
// a beat waits in the input register, is evaluated against the clock
// state in a single combinational pass (one 32 by 8 multiplier for the swing
// amount and one deadline adder and compare), and is written into the result
// register when that register is empty or being emptied. The result register
// lets a new beat enter while the previous result still waits: o_stall rises
// only when both the input and the result register are full and the
// downstream side stalls. clock_mode and swing_fraction are written through
// the plain write port (index 0 and 1) and must only change while the block
// is idle. Step lengths written with a length beat are clamped to
// 32000..1024000 us; in MIDI mode the measured length is used unclamped.
module sequencer_step_clock_with_swing #(
    parameter int unsigned PULSES_PER_STEP = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input beats.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_func,
    input  logic                          i_midi_pulse,
    input  logic                          i_trigger_pulse,
    input  logic [31:0]                   i_new_step_length,
    // Result beats.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_step_now,
    output logic [15:0]                   o_step_index,
    output logic [31:0]                   o_current_step_length,
    // Configuration writes.
    input  logic                          i_cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [scs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import scs_pkg::*;

    logic        r_in_vld;
    t_scs_item   r_in;
    logic        r_out_vld;
    t_scs_result r_out;
    t_scs_cfg    r_cfg;

    logic        out_free;
    logic        fire;
    logic        in_take;
    t_scs_result res;

    // The evaluation fires whenever an input beat is held and the result
    // register is empty or is being emptied in this cycle.
    assign out_free = !r_out_vld || !i_stall;
    assign fire     = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.func            <= i_func;
            r_in.midi_pulse      <= i_midi_pulse;
            r_in.trigger_pulse   <= i_trigger_pulse;
            r_in.new_step_length <= i_new_step_length;
        end
    end

    scs_core #(
        .PULSES_PER_STEP (PULSES_PER_STEP)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    // Configuration registers; the mode register keeps the low two bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_mode     <= MODE_INTERNAL;
            r_cfg.swing_fraction <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLOCK_MODE: r_cfg.clock_mode     <= i_cfg_wdata[1:0];
                CFG_SWING:      r_cfg.swing_fraction <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_valid               = r_out_vld;
    assign o_step_now            = r_out.step_now;
    assign o_step_index          = r_out.step_index;
    assign o_current_step_length = r_out.step_length;

    a_stall_needs_held_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_vld && r_out_vld))
        else $error("input stalled without a held beat and a full result register");

    a_held_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !fire) |=> r_in_vld)
        else $error("held input beat dropped before evaluation");

    a_fire_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("evaluated beat did not reach the result register");

endmodule
